// ===== hw/rtl/sss_pkg.sv =====
package sss_pkg;

  localparam int unsigned MAX_PATTERN = 8;
  localparam int unsigned POS_BITS    = 16;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned PAT_W    = 64;
  localparam int unsigned PLEN_W   = 4;
  localparam int unsigned START_W  = 16;
  localparam int unsigned WIN_W    = BYTE_W * MAX_PATTERN;
  localparam int unsigned LEN_BITS = $clog2(MAX_PATTERN + 1);
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BYTES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LEN   = 1'b1;

  typedef struct packed {
    logic [WIN_W-1:0]    window;
    logic [POS_BITS-1:0] position;
    logic                reported;
  } state_t;

  typedef struct packed {
    logic               valid;
    logic               found;
    logic [START_W-1:0] match_start;
  } result_t;

endpackage

// ===== hw/rtl/sss_match.sv =====
module sss_match (
  input  logic [sss_pkg::BYTE_W-1:0] text_byte_i,
  input  sss_pkg::state_t            state_i,
  input  logic [sss_pkg::PAT_W-1:0]  pattern_i,
  input  logic [sss_pkg::PLEN_W-1:0] pattern_len_i,
  output sss_pkg::state_t            state_o,
  output sss_pkg::result_t           result_o
);

  logic [sss_pkg::LEN_BITS-1:0]               clamp_len;
  logic [sss_pkg::LEN_BITS-1:0]               use_len;
  logic [sss_pkg::WIN_W-1:0]                  pat_win;
  logic [sss_pkg::WIN_W+sss_pkg::BYTE_W-1:0]  win_ext;
  logic [sss_pkg::WIN_W-1:0]                  win_nxt;
  logic [sss_pkg::WIN_W-1:0]                  recent;
  logic [sss_pkg::WIN_W-1:0]                  mask;
  logic [sss_pkg::LEN_BITS-1:0]               shift_bytes;
  logic [sss_pkg::POS_BITS-1:0]               pos_inc;
  logic [sss_pkg::POS_BITS-1:0]               start;
  logic                                       hit;

  assign pat_win = pattern_i[sss_pkg::WIN_W-1:0];

  always_comb begin
    if (pattern_len_i > sss_pkg::PLEN_W'(sss_pkg::MAX_PATTERN)) begin
      clamp_len = sss_pkg::LEN_BITS'(sss_pkg::MAX_PATTERN);
    end else begin
      clamp_len = sss_pkg::LEN_BITS'(pattern_len_i);
    end
  end

  // pattern ends at its first zero byte
  always_comb begin
    use_len = clamp_len;
    for (int i = sss_pkg::MAX_PATTERN - 1; i >= 0; i--) begin
      if ((sss_pkg::LEN_BITS'(i) < clamp_len) &&
          (pat_win[i*sss_pkg::BYTE_W +: sss_pkg::BYTE_W] == '0)) begin
        use_len = sss_pkg::LEN_BITS'(i);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < sss_pkg::MAX_PATTERN; i++) begin
      mask[i*sss_pkg::BYTE_W +: sss_pkg::BYTE_W] =
        {sss_pkg::BYTE_W{sss_pkg::LEN_BITS'(i) < use_len}};
    end
  end

  assign win_ext     = {text_byte_i, state_i.window};
  assign win_nxt     = win_ext[sss_pkg::WIN_W+sss_pkg::BYTE_W-1:sss_pkg::BYTE_W];
  assign shift_bytes = sss_pkg::LEN_BITS'(sss_pkg::MAX_PATTERN) - use_len;
  assign recent      = win_nxt >> {shift_bytes, 3'b000};
  assign hit         = (((recent ^ pat_win) & mask) == '0);

  assign pos_inc = (state_i.position == '1) ? state_i.position
                                            : state_i.position + 1'b1;
  assign start   = state_i.position - sss_pkg::POS_BITS'(use_len) + 1'b1;

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    if (text_byte_i == '0) begin
      state_o = '0;
      if (!state_i.reported) begin
        result_o.valid = 1'b1;
        result_o.found = (use_len == '0);
      end
    end else begin
      state_o.window   = win_nxt;
      state_o.position = pos_inc;
      if (!state_i.reported) begin
        if (use_len == '0) begin
          result_o.valid   = 1'b1;
          result_o.found   = 1'b1;
          state_o.reported = 1'b1;
        end else if (hit) begin
          result_o.valid       = 1'b1;
          result_o.found       = 1'b1;
          result_o.match_start = sss_pkg::START_W'(start);
          state_o.reported     = 1'b1;
        end
      end
    end
  end

endmodule

// ===== hw/rtl/substring_search.sv =====
// substring_search: first-match search of a short pattern in a NUL-ended byte stream.
//
// Configure through cfg_we_i/cfg_idx_i/cfg_wdata_i while idle: index 0 holds the
// pattern bytes (first byte lowest), index 1 the pattern length (0 = empty).
// Text enters one byte per word on in_valid_i/in_stall_o; a zero byte ends the string
// and re-arms the search for the next one.
// One result word per string leaves on out_valid_o/out_stall_i: found_o=1 with
// match_start_o on the byte that completes the first match, or found_o=0 on the NUL
// if nothing matched. Other bytes give no word.
// After its byte is accepted, a result word passes the input register and then the
// result register, from which it is presented. Throughput: one byte per cycle unless
// the output stalls, set by the combinational window compare and state update.
// When the receiver stalls with a result pending, the block keeps taking one more
// byte into its input register and then stalls the input until the result is taken.
// Reset clears the pattern, its length, the window, the position and the pending
// word; the first byte can be accepted right after reset.
module substring_search (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [sss_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [sss_pkg::PAT_W-1:0]       cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [sss_pkg::BYTE_W-1:0]      text_byte_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic                            found_o,
  output logic [sss_pkg::START_W-1:0]     match_start_o
);

  logic [sss_pkg::PAT_W-1:0]  pattern_q;
  logic [sss_pkg::PLEN_W-1:0] pattern_len_q;
  logic                       s1_valid_q;
  logic [sss_pkg::BYTE_W-1:0] s1_byte_q;
  sss_pkg::state_t            state_q;
  sss_pkg::state_t            state_d;
  sss_pkg::result_t           res_d;
  sss_pkg::result_t           out_q;
  logic                       advance;
  logic                       in_accept;

  assign advance    = !out_q.valid || !out_stall_i;
  assign in_stall_o = s1_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q     <= '0;
      pattern_len_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        sss_pkg::CFG_PATTERN_BYTES: pattern_q     <= cfg_wdata_i;
        sss_pkg::CFG_PATTERN_LEN:   pattern_len_q <= cfg_wdata_i[sss_pkg::PLEN_W-1:0];
        default: ;
      endcase
    end
  end

  sss_match u_match (
    .text_byte_i  (s1_byte_q),
    .state_i      (state_q),
    .pattern_i    (pattern_q),
    .pattern_len_i(pattern_len_q),
    .state_o      (state_d),
    .result_o     (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_accept) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_byte_q <= text_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
      out_q   <= '0;
    end else if (advance) begin
      if (s1_valid_q) begin
        state_q <= state_d;
        out_q   <= res_d;
      end else begin
        out_q.valid <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_q.valid;
  assign found_o       = out_q.found;
  assign match_start_o = out_q.match_start;

  a_stall_needs_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_q.valid)
    else $error("input stalled without a pending byte and word");

  a_nul_rearms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && s1_valid_q && (s1_byte_q == '0) |=>
      (state_q.window == '0) && (state_q.position == '0) && !state_q.reported)
    else $error("NUL did not re-arm the search");

  a_report_gives_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q.reported) |-> out_q.valid && out_q.found)
    else $error("match recorded without a found word");

  a_miss_start_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_q.valid && !out_q.found |-> out_q.match_start == '0)
    else $error("miss word carries a nonzero start");

endmodule
